// ----- rtl/ckpt_pkg.sv -----
// Shared record type, operation and status codes, limits for the checkpoint index table.
package ckpt_pkg;

    typedef struct packed {
        logic        side;
        logic [31:0] lag;
        logic [30:0] size;
        logic [31:0] frame;
    } rec_t;

    localparam logic [2:0] MODE_CAPTURE = 3'd0;
    localparam logic [2:0] MODE_INVAL   = 3'd1;
    localparam logic [2:0] MODE_FIND    = 3'd2;
    localparam logic [2:0] MODE_CLEAR   = 3'd3;
    localparam logic [2:0] MODE_TRIM    = 3'd4;
    localparam logic [2:0] MODE_READ    = 3'd5;

    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_NOT_DUE   = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE = 3'd3;
    localparam logic [2:0] ST_DONE      = 3'd4;
    localparam logic [2:0] ST_FOUND     = 3'd5;
    localparam logic [2:0] ST_NONE      = 3'd6;
    localparam logic [2:0] ST_BAD_SLOT  = 3'd7;

    localparam int         CFG_ADDR_W   = 2;
    localparam logic [1:0] REG_BUDGET   = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;

    localparam logic [30:0] BUDGET_MAX   = 31'd1073741824;
    localparam logic [11:0] INTERVAL_MAX = 12'd3600;

endpackage

// ----- rtl/ckpt_rem.sv -----
// Bit-serial remainder unit: frame modulo capture interval, one bit per cycle.
module ckpt_rem
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [11:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [11:0] rem
);

    logic [5:0]  cnt_reg;
    logic [31:0] quo_reg;
    logic [11:0] rem_reg;
    logic [11:0] div_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [12:0] trial;

    // shift in the next dividend bit
    assign trial = {rem_reg, quo_reg[31]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                div_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (trial >= {1'b0, div_reg})
                begin
                    rem_reg <= 12'(trial - {1'b0, div_reg});
                end
                else
                begin
                    rem_reg <= trial[11:0];
                end
                quo_reg <= {quo_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/ckpt_mem.sv -----
// Record store: one write port, one read port, registered read data.
module ckpt_mem #(
    parameter int SLOTS = 16,
    parameter int IW    = 4
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [IW-1:0]     waddr,
    input  ckpt_pkg::rec_t    wdata,
    input  logic [IW-1:0]     raddr,
    output ckpt_pkg::rec_t    rdata
);

    ckpt_pkg::rec_t mem [SLOTS];
    ckpt_pkg::rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/checkpoint_index_table_unit.sv -----
// Checkpoint index table: sequencer, ring-ordered record store and remainder unit.
// Steps per mode: clear, unused modes, bad slot and a capture gated off before the remainder
//   check go straight to the result; read slot waits on the registered read; find and invalidate
//   walk the held records; trim drops the oldest record while the bytes held exceed the budget.
// Capture: remainder unit first, ending there off the interval; then one pass over the store at
//   one record a cycle to check duplicates, then a size check, evictions and the store of the record.
// Throughput: one item at a time; s_tready rises once the result is registered.
// Reset: table empty, budget 0, interval 1; store contents stay undefined, never read.
module checkpoint_index_table_unit #(
    parameter int SLOTS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // frame[31:0], busy_frame[32], snapshot_size[63:33], lag_total[95:64],
    // side[96], slot_index[100:97], zero pad[103:101]
    input  logic [103:0]  s_tdata,
    // mode[2:0]
    input  logic [2:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // hit_frame[31:0], hit_size[62:32], hit_lag[94:63], hit_side[95], hit_slot[99:96],
    // entry_count[104:100], bytes_used[135:105]
    output logic [135:0]  m_tdata,
    // status[2:0]
    output logic [2:0]    m_tuser,
    input  logic          cfg_we,
    input  logic [ckpt_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [30:0]   cfg_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_SCAN, S_EVICT, S_EVSUB, S_TRIM, S_RDWAIT, S_FIN
    } state_t;

    state_t         state_reg;
    logic [30:0]    budget_reg;
    logic [11:0]    interval_reg;
    logic [IW-1:0]  head_reg;
    logic [CW-1:0]  count_reg;
    logic [30:0]    bytes_reg;

    logic [2:0]     req_mode_reg;
    ckpt_pkg::rec_t req_rec_reg;

    logic [CW-1:0]  rd_i_reg;
    logic [CW-1:0]  k_reg;
    logic           dv_reg;
    logic [CW-1:0]  di_reg;
    logic           found_reg;
    logic           dup_reg;
    ckpt_pkg::rec_t best_reg;
    logic [3:0]     best_slot_reg;
    logic [2:0]     status_reg;
    logic           evict_trim_reg;

    logic           m_tvalid_reg;
    ckpt_pkg::rec_t out_hit_reg;
    logic [3:0]     out_slot_reg;
    logic [4:0]     out_count_reg;
    logic [30:0]    out_bytes_reg;
    logic [2:0]     out_status_reg;

    // unpacked input fields
    logic [31:0]    in_frame;
    logic           in_busy;
    logic [30:0]    in_size;
    logic [31:0]    in_lag;
    logic           in_side;
    logic [3:0]     in_slot;

    assign in_frame = s_tdata[31:0];
    assign in_busy  = s_tdata[32];
    assign in_size  = s_tdata[63:33];
    assign in_lag   = s_tdata[95:64];
    assign in_side  = s_tdata[96];
    assign in_slot  = s_tdata[100:97];

    // position in the ring, wrapping once past the last slot
    function automatic logic [IW-1:0] wadd(input logic [IW-1:0] a, input logic [IW-1:0] b);
        logic [IW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IW+1)'(SLOTS))
        begin
            s = s - (IW+1)'(SLOTS);
        end
        return s[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] cidx(input logic [CW-1:0] c);
        logic [31:0] e;
        e = 32'(c);
        return e[IW-1:0];
    endfunction

    function automatic logic [3:0] cslot(input logic [CW-1:0] c);
        logic [31:0] e;
        e = 32'(c);
        return e[3:0];
    endfunction

    logic [31:0] slot_ext;
    logic [31:0] count_ext;
    assign slot_ext  = 32'(in_slot);
    assign count_ext = 32'(count_reg);

    // store and remainder unit
    logic           mem_we;
    logic [IW-1:0]  mem_waddr;
    ckpt_pkg::rec_t mem_wdata;
    logic [IW-1:0]  mem_raddr;
    ckpt_pkg::rec_t mem_rdata;

    logic           rem_start;
    logic           rem_busy;
    logic           rem_done;
    logic [11:0]    rem_val;

    ckpt_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ckpt_rem u_rem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (in_frame),
        .divisor  (interval_reg),
        .busy     (rem_busy),
        .done     (rem_done),
        .rem      (rem_val)
    );

    logic accept;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // capture gate checked before the remainder unit is started
    assign rem_start = accept && (s_tuser == ckpt_pkg::MODE_CAPTURE) && (in_frame != 32'd0)
                       && !in_busy && (budget_reg != 31'd0);

    // eviction conditions: capture makes room, trim obeys the budget
    logic [31:0] bytes_plus;
    logic        ev_cond;
    logic        tr_cond;
    logic        keep;
    logic        scan_end;

    assign bytes_plus = {1'b0, bytes_reg} + {1'b0, req_rec_reg.size};
    assign ev_cond    = (count_reg != '0) &&
                        ((count_ext >= 32'(SLOTS)) || (bytes_plus > {1'b0, budget_reg}));
    assign tr_cond    = (count_reg != '0) && (bytes_reg > budget_reg);
    assign keep       = (mem_rdata.frame <= req_rec_reg.frame);
    assign scan_end   = (rd_i_reg == count_reg) && !dv_reg;

    // read address: slot read at accept, ring walk during a scan, oldest record otherwise
    always_comb
    begin
        mem_raddr = head_reg;
        if (state_reg == S_IDLE)
        begin
            mem_raddr = wadd(head_reg, slot_ext[IW-1:0]);
        end
        else if (state_reg == S_SCAN)
        begin
            mem_raddr = wadd(head_reg, cidx(rd_i_reg));
        end
    end

    // write: compaction during invalidate, append at the tail on capture
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wadd(head_reg, cidx(k_reg));
        mem_wdata = mem_rdata;
        if ((state_reg == S_SCAN) && dv_reg && (req_mode_reg == ckpt_pkg::MODE_INVAL) && keep)
        begin
            mem_we = 1'b1;
        end
        else if ((state_reg == S_EVICT) && !ev_cond)
        begin
            mem_we    = 1'b1;
            mem_waddr = wadd(head_reg, cidx(count_reg));
            mem_wdata = req_rec_reg;
        end
    end

    // configuration: out-of-range values are dropped; interval uses the low 12 bits only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg   <= '0;
            interval_reg <= 12'd1;
        end
        else if (cfg_we)
        begin
            if ((cfg_addr == ckpt_pkg::REG_BUDGET) && (cfg_data <= ckpt_pkg::BUDGET_MAX))
            begin
                budget_reg <= cfg_data;
            end
            else if ((cfg_addr == ckpt_pkg::REG_INTERVAL) && (cfg_data[11:0] != 12'd0)
                     && (cfg_data[11:0] <= ckpt_pkg::INTERVAL_MAX))
            begin
                interval_reg <= cfg_data[11:0];
            end
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            bytes_reg      <= '0;
            req_mode_reg   <= '0;
            req_rec_reg    <= '0;
            rd_i_reg       <= '0;
            k_reg          <= '0;
            dv_reg         <= 1'b0;
            di_reg         <= '0;
            found_reg      <= 1'b0;
            dup_reg        <= 1'b0;
            best_reg       <= '0;
            best_slot_reg  <= '0;
            status_reg     <= '0;
            evict_trim_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            out_hit_reg    <= '0;
            out_slot_reg   <= '0;
            out_count_reg  <= '0;
            out_bytes_reg  <= '0;
            out_status_reg <= '0;
        end
        else
        begin
            // drop the result once taken, unless a new one is loaded this cycle
            if (m_tvalid_reg && m_tready && (state_reg != S_FIN))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_mode_reg <= s_tuser;
                        req_rec_reg  <= '{side: in_side, lag: in_lag, size: in_size,
                                          frame: in_frame};
                        rd_i_reg     <= '0;
                        k_reg        <= '0;
                        dv_reg       <= 1'b0;
                        found_reg    <= 1'b0;
                        dup_reg      <= 1'b0;
                        case (s_tuser)
                            ckpt_pkg::MODE_CAPTURE:
                            begin
                                status_reg <= ckpt_pkg::ST_NOT_DUE;
                                state_reg  <= rem_start ? S_DIV : S_FIN;
                            end
                            ckpt_pkg::MODE_INVAL, ckpt_pkg::MODE_FIND:
                            begin
                                status_reg <= ckpt_pkg::ST_DONE;
                                state_reg  <= S_SCAN;
                            end
                            ckpt_pkg::MODE_CLEAR:
                            begin
                                count_reg  <= '0;
                                bytes_reg  <= '0;
                                head_reg   <= '0;
                                status_reg <= ckpt_pkg::ST_DONE;
                                state_reg  <= S_FIN;
                            end
                            ckpt_pkg::MODE_TRIM:
                            begin
                                evict_trim_reg <= 1'b1;
                                status_reg     <= ckpt_pkg::ST_DONE;
                                state_reg      <= S_TRIM;
                            end
                            ckpt_pkg::MODE_READ:
                            begin
                                best_slot_reg <= in_slot;
                                if (slot_ext < count_ext)
                                begin
                                    status_reg <= ckpt_pkg::ST_DONE;
                                    state_reg  <= S_RDWAIT;
                                end
                                else
                                begin
                                    status_reg <= ckpt_pkg::ST_BAD_SLOT;
                                    state_reg  <= S_FIN;
                                end
                            end
                            default:
                            begin
                                status_reg <= ckpt_pkg::ST_DONE;
                                state_reg  <= S_FIN;
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (rem_done)
                    begin
                        state_reg <= (rem_val == 12'd0) ? S_SCAN : S_FIN;
                    end
                end
                S_SCAN:
                begin
                    // issue one read a cycle; data returns from the registered read port in the next cycle
                    if (rd_i_reg != count_reg)
                    begin
                        rd_i_reg <= rd_i_reg + CW'(1);
                        dv_reg   <= 1'b1;
                        di_reg   <= rd_i_reg;
                    end
                    else
                    begin
                        dv_reg <= 1'b0;
                    end
                    if (dv_reg)
                    begin
                        case (req_mode_reg)
                            ckpt_pkg::MODE_CAPTURE:
                            begin
                                if (mem_rdata.frame == req_rec_reg.frame)
                                begin
                                    dup_reg <= 1'b1;
                                end
                            end
                            ckpt_pkg::MODE_FIND:
                            begin
                                if (keep && (!found_reg || (mem_rdata.frame >= best_reg.frame)))
                                begin
                                    found_reg     <= 1'b1;
                                    best_reg      <= mem_rdata;
                                    best_slot_reg <= cslot(di_reg);
                                end
                            end
                            default:
                            begin
                                // invalidate: keep older records packed toward the head
                                if (keep)
                                begin
                                    k_reg <= k_reg + CW'(1);
                                end
                                else
                                begin
                                    bytes_reg <= bytes_reg - mem_rdata.size;
                                end
                            end
                        endcase
                    end
                    if (scan_end)
                    begin
                        case (req_mode_reg)
                            ckpt_pkg::MODE_CAPTURE:
                            begin
                                if (dup_reg)
                                begin
                                    status_reg <= ckpt_pkg::ST_DUPLICATE;
                                    state_reg  <= S_FIN;
                                end
                                else if (req_rec_reg.size > budget_reg)
                                begin
                                    status_reg <= ckpt_pkg::ST_TOO_LARGE;
                                    state_reg  <= S_FIN;
                                end
                                else
                                begin
                                    evict_trim_reg <= 1'b0;
                                    state_reg      <= S_EVICT;
                                end
                            end
                            ckpt_pkg::MODE_FIND:
                            begin
                                status_reg <= found_reg ? ckpt_pkg::ST_FOUND : ckpt_pkg::ST_NONE;
                                state_reg  <= S_FIN;
                            end
                            default:
                            begin
                                count_reg  <= k_reg;
                                status_reg <= ckpt_pkg::ST_DONE;
                                state_reg  <= S_FIN;
                            end
                        endcase
                    end
                end
                S_EVICT:
                begin
                    if (ev_cond)
                    begin
                        state_reg <= S_EVSUB;
                    end
                    else
                    begin
                        count_reg  <= count_reg + CW'(1);
                        bytes_reg  <= bytes_reg + req_rec_reg.size;
                        status_reg <= ckpt_pkg::ST_STORED;
                        state_reg  <= S_FIN;
                    end
                end
                S_EVSUB:
                begin
                    // drop the oldest record; its size is on the read port now
                    bytes_reg <= bytes_reg - mem_rdata.size;
                    count_reg <= count_reg - CW'(1);
                    head_reg  <= wadd(head_reg, IW'(1));
                    state_reg <= evict_trim_reg ? S_TRIM : S_EVICT;
                end
                S_TRIM:
                begin
                    state_reg <= tr_cond ? S_EVSUB : S_FIN;
                end
                S_RDWAIT:
                begin
                    best_reg   <= mem_rdata;
                    status_reg <= ckpt_pkg::ST_FOUND;
                    state_reg  <= S_FIN;
                end
                S_FIN:
                begin
                    // hold the result until the output register is free
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg   <= 1'b1;
                        out_status_reg <= status_reg;
                        out_count_reg  <= count_ext[4:0];
                        out_bytes_reg  <= bytes_reg;
                        if (status_reg == ckpt_pkg::ST_FOUND)
                        begin
                            out_hit_reg  <= best_reg;
                            out_slot_reg <= best_slot_reg;
                        end
                        else
                        begin
                            out_hit_reg  <= '0;
                            out_slot_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_bytes_reg, out_count_reg, out_slot_reg, out_hit_reg.side,
                       out_hit_reg.lag, out_hit_reg.size, out_hit_reg.frame};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_ext <= 32'(SLOTS))
        else $error("record count above slot limit");

    a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_reg <= ckpt_pkg::BUDGET_MAX)
        else $error("held bytes above budget ceiling");

    a_empty_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (bytes_reg == '0))
        else $error("empty table holds bytes");

    a_rem_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rem_busy |-> (state_reg == S_DIV))
        else $error("remainder unit busy outside capture check");

endmodule
